/* sv/cal_pkg.sv */
// Package for the cursor array list: request and result payloads, op codes,
// controller state type and the controller-to-datapath command and status structs.
// No dependencies.
package cal_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_END    = 3'd3;
    localparam logic [2:0] OP_PREV   = 3'd4;
    localparam logic [2:0] OP_NEXT   = 3'd5;
    localparam logic [2:0] OP_POS    = 3'd6;

    localparam logic signed [31:0] NO_VALUE = -32'sd1;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] new_value;
        logic [5:0]         target_position;
    } cal_request_t;

    typedef struct packed {
        logic signed [31:0] cursor_value;
        logic               cursor_value_valid;
        logic [6:0]         list_length;
        logic [6:0]         cursor_index;
        logic               accepted;
    } cal_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UP_RD,
        ST_UP_WR,
        ST_INS_FIN,
        ST_DN_RD,
        ST_DN_WR,
        ST_REM_FIN,
        ST_CUR_RD,
        ST_EMIT
    } cal_state_t;

    typedef struct packed {
        logic latch;
        logic move;
        logic idx_load_count;
        logic idx_load_cursor;
        logic rd_up;
        logic rd_dn;
        logic wr_up;
        logic wr_dn;
        logic ins_fin;
        logic rem_fin;
        logic cur_rd;
    } cal_dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       ins_ok;
        logic       rem_ok;
        logic       idx_gt_cur;
        logic       idx_next_lt_cnt;
    } cal_dp_sts_t;

endpackage

/* sv/cursor_array_list.sv */
// Top level of the cursor array list: controller and datapath joined.
// Depends on cal_pkg, cal_ctrl and cal_dp.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  request  | start high, busy low | request (cal_pkg::cal_request_t)
//  result   | done, one cycle      | result  (cal_pkg::cal_result_t)
//
// A move transfer keeps busy high through the decode, cursor read and emit states; done rises in emit.
// Accepted insert with n entries and cursor c moves entries c..n-1 up one place, then
// writes the new value at c; accepted remove moves c+1..n-1 down; refused: cursor read.
// Each shifted entry is a read and then a write on the single memory port pair.
// Reset empties the list and puts the cursor at 0; entry memory is not cleared.
// The result is marked by done for one cycle only and cannot be held off.
module cursor_array_list
#(
    parameter int CAPACITY = cal_pkg::CAPACITY_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  cal_pkg::cal_request_t request,
    output logic                  busy,
    output logic                  done,
    output cal_pkg::cal_result_t  result
);

    cal_pkg::cal_dp_cmd_t dp_cmd;
    cal_pkg::cal_dp_sts_t dp_sts;

    cal_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sts    (dp_sts),
        .dp_cmd (dp_cmd),
        .busy   (busy),
        .done   (done)
    );

    cal_dp
    #(
        .CAPACITY (CAPACITY)
    )
    u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .dp_cmd  (dp_cmd),
        .sts     (dp_sts),
        .result  (result)
    );

endmodule

/* sv/cal_ctrl.sv */
// Controller state machine for the cursor array list.
// Sequences shifts, list updates and the cursor read; depends on cal_pkg.
module cal_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cal_pkg::cal_dp_sts_t sts,
    output cal_pkg::cal_dp_cmd_t dp_cmd,
    output logic                 busy,
    output logic                 done
);

    cal_pkg::cal_state_t state_reg;
    cal_pkg::cal_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cal_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        busy       = (state_reg != cal_pkg::ST_IDLE);
        done       = (state_reg == cal_pkg::ST_EMIT);
        unique case (state_reg)
            cal_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.latch = 1'b1;
                    state_next   = cal_pkg::ST_DECODE;
                end
            end
            cal_pkg::ST_DECODE:
            begin
                unique case (sts.op) inside
                    cal_pkg::OP_INSERT:
                    begin
                        if (sts.ins_ok)
                        begin
                            dp_cmd.idx_load_count = 1'b1;
                            state_next            = cal_pkg::ST_UP_RD;
                        end
                        else
                        begin
                            state_next = cal_pkg::ST_CUR_RD;
                        end
                    end
                    cal_pkg::OP_REMOVE:
                    begin
                        if (sts.rem_ok)
                        begin
                            dp_cmd.idx_load_cursor = 1'b1;
                            state_next             = cal_pkg::ST_DN_RD;
                        end
                        else
                        begin
                            state_next = cal_pkg::ST_CUR_RD;
                        end
                    end
                    cal_pkg::OP_START, cal_pkg::OP_END, cal_pkg::OP_PREV,
                    cal_pkg::OP_NEXT, cal_pkg::OP_POS:
                    begin
                        dp_cmd.move = 1'b1;
                        state_next  = cal_pkg::ST_CUR_RD;
                    end
                    default:
                    begin
                        state_next = cal_pkg::ST_CUR_RD;
                    end
                endcase
            end
            cal_pkg::ST_UP_RD:
            begin
                if (sts.idx_gt_cur)
                begin
                    dp_cmd.rd_up = 1'b1;
                    state_next   = cal_pkg::ST_UP_WR;
                end
                else
                begin
                    state_next = cal_pkg::ST_INS_FIN;
                end
            end
            cal_pkg::ST_UP_WR:
            begin
                dp_cmd.wr_up = 1'b1;
                state_next   = cal_pkg::ST_UP_RD;
            end
            cal_pkg::ST_INS_FIN:
            begin
                dp_cmd.ins_fin = 1'b1;
                state_next     = cal_pkg::ST_CUR_RD;
            end
            cal_pkg::ST_DN_RD:
            begin
                if (sts.idx_next_lt_cnt)
                begin
                    dp_cmd.rd_dn = 1'b1;
                    state_next   = cal_pkg::ST_DN_WR;
                end
                else
                begin
                    state_next = cal_pkg::ST_REM_FIN;
                end
            end
            cal_pkg::ST_DN_WR:
            begin
                dp_cmd.wr_dn = 1'b1;
                state_next   = cal_pkg::ST_DN_RD;
            end
            cal_pkg::ST_REM_FIN:
            begin
                dp_cmd.rem_fin = 1'b1;
                state_next     = cal_pkg::ST_CUR_RD;
            end
            cal_pkg::ST_CUR_RD:
            begin
                dp_cmd.cur_rd = 1'b1;
                state_next    = cal_pkg::ST_EMIT;
            end
            cal_pkg::ST_EMIT:
            begin
                state_next = cal_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cal_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/cal_dp.sv */
// Datapath for the cursor array list: entry memory, length, cursor, shift index
// and result assembly. Driven by cal_ctrl; depends on cal_pkg.
module cal_dp
#(
    parameter int CAPACITY = cal_pkg::CAPACITY_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cal_pkg::cal_request_t request,
    input  cal_pkg::cal_dp_cmd_t  dp_cmd,
    output cal_pkg::cal_dp_sts_t  sts,
    output cal_pkg::cal_result_t  result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

    logic [31:0] mem [CAPACITY];
    logic [31:0] rdata_reg;

    logic [2:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [5:0]         tgt_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      cursor_reg, cursor_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               ok_reg, ok_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0]   mem_wd;

    logic [CW-1:0] idx_dec;
    logic [CW:0]   idx_inc;
    logic [CW:0]   cur_inc;
    logic [CW+5:0] tgt_ext;
    logic [CW+5:0] cnt_ext6;
    logic [CW+6:0] len_ext;
    logic [CW+6:0] cur_ext;
    logic          cur_valid;
    logic [CW-1:0] mv_cursor;
    logic          mv_ok;

    assign idx_dec   = idx_reg - CNT_ONE;
    assign idx_inc   = {1'b0, idx_reg} + {1'b0, CNT_ONE};
    assign cur_inc   = {1'b0, cursor_reg} + {1'b0, CNT_ONE};
    assign tgt_ext   = {{CW{1'b0}}, tgt_reg};
    assign cnt_ext6  = {6'b0, count_reg};
    assign len_ext   = {7'b0, count_reg};
    assign cur_ext   = {7'b0, cursor_reg};
    assign cur_valid = (cursor_reg < count_reg);

    assign sts.op              = op_reg;
    assign sts.ins_ok          = (count_reg < CNT_CAP);
    assign sts.rem_ok          = cur_valid;
    assign sts.idx_gt_cur      = (idx_reg > cursor_reg);
    assign sts.idx_next_lt_cnt = (idx_inc < {1'b0, count_reg});

    always_comb
    begin
        mv_cursor = cursor_reg;
        mv_ok     = 1'b0;
        case (op_reg)
            cal_pkg::OP_START:
            begin
                mv_cursor = '0;
                mv_ok     = 1'b1;
            end
            cal_pkg::OP_END:
            begin
                mv_cursor = (count_reg == '0) ? '0 : count_reg - CNT_ONE;
                mv_ok     = 1'b1;
            end
            cal_pkg::OP_PREV:
            begin
                if (cursor_reg != '0)
                begin
                    mv_cursor = cursor_reg - CNT_ONE;
                    mv_ok     = 1'b1;
                end
            end
            cal_pkg::OP_NEXT:
            begin
                if (cur_inc < {1'b0, count_reg})
                begin
                    mv_cursor = cur_inc[CW-1:0];
                    mv_ok     = 1'b1;
                end
            end
            cal_pkg::OP_POS:
            begin
                if (tgt_ext < cnt_ext6)
                begin
                    mv_cursor = tgt_ext[CW-1:0];
                    mv_ok     = 1'b1;
                end
            end
            default:
            begin
                mv_cursor = cursor_reg;
                mv_ok     = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        ok_next     = ok_reg;
        if (dp_cmd.latch)
        begin
            ok_next = 1'b0;
        end
        if (dp_cmd.move)
        begin
            cursor_next = mv_cursor;
            ok_next     = mv_ok;
        end
        if (dp_cmd.idx_load_count)
        begin
            idx_next = count_reg;
        end
        if (dp_cmd.idx_load_cursor)
        begin
            idx_next = cursor_reg;
        end
        if (dp_cmd.wr_up)
        begin
            idx_next = idx_dec;
        end
        if (dp_cmd.wr_dn)
        begin
            idx_next = idx_inc[CW-1:0];
        end
        if (dp_cmd.ins_fin)
        begin
            count_next = count_reg + CNT_ONE;
            ok_next    = 1'b1;
        end
        if (dp_cmd.rem_fin)
        begin
            count_next = count_reg - CNT_ONE;
            ok_next    = 1'b1;
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = idx_reg[AW-1:0];
        mem_wd = rdata_reg;
        mem_re = 1'b0;
        mem_ra = cursor_reg[AW-1:0];
        if (dp_cmd.rd_up)
        begin
            mem_re = 1'b1;
            mem_ra = idx_dec[AW-1:0];
        end
        if (dp_cmd.rd_dn)
        begin
            mem_re = 1'b1;
            mem_ra = idx_inc[AW-1:0];
        end
        if (dp_cmd.cur_rd && cur_valid)
        begin
            mem_re = 1'b1;
            mem_ra = cursor_reg[AW-1:0];
        end
        if (dp_cmd.wr_up || dp_cmd.wr_dn)
        begin
            mem_we = 1'b1;
            mem_wa = idx_reg[AW-1:0];
            mem_wd = rdata_reg;
        end
        if (dp_cmd.ins_fin)
        begin
            mem_we = 1'b1;
            mem_wa = cursor_reg[AW-1:0];
            mem_wd = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    // hold the request fields for the whole transfer
    always_ff @(posedge clk)
    begin
        if (dp_cmd.latch)
        begin
            op_reg  <= request.op;
            val_reg <= request.new_value;
            tgt_reg <= request.target_position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= '0;
            idx_reg    <= '0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            idx_reg    <= idx_next;
            ok_reg     <= ok_next;
        end
    end

    assign result.cursor_value       = cur_valid ? rdata_reg : cal_pkg::NO_VALUE;
    assign result.cursor_value_valid = cur_valid;
    assign result.list_length        = len_ext[6:0];
    assign result.cursor_index       = cur_ext[6:0];
    assign result.accepted           = ok_reg;

endmodule
